// ===== sv/carc_pkg.sv =====
// Shared sizes, status codes and register indexes of the call arc counter.
package carc_pkg;

	localparam int BUCKETS      = 4096;
	localparam int ARCS         = 4096;
	localparam int BUCKET_BYTES = 4;
	localparam int HARD_LIMIT   = 65534;

	localparam int BKT_W   = $clog2(BUCKETS);
	localparam int ARC_W   = $clog2(ARCS);
	// least of ARCS and the hard limit
	localparam int ARC_CAP = (ARCS < HARD_LIMIT) ? ARCS : HARD_LIMIT;

	localparam int STATUS_W = 3;
	localparam int INDEX_W  = 16;
	localparam int COUNT_W  = 32;
	localparam int PC_W     = 32;

	localparam logic [STATUS_W-1:0] STAT_HEAD_HIT = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_MOVED    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_NEW      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_OFF      = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 3'd5;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BASE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_SIZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ARC_LIMIT = 3'd3;

	localparam int TEXT_SIZE_W = 15;
	localparam int ARC_LIMIT_W = 13;

endpackage

// ===== sv/call_arc_counter_core.sv =====
// Call-graph arc recorder: bucket heads, arc table and the chain-walk sequencer.
//
// Input stream s_*: one call event per request, caller_pc in s_tdata[31:0] and
// callee_pc in s_tdata[63:32]. Output stream m_*: one result per event with
// status, arc_index and arc_count. Configuration goes through cfg_wen,
// cfg_index and cfg_wdata; it is to be written by the user only while no event
// is in flight, which the block itself does not enforce. One event is worked
// at a time; s_tready is high only while the sequencer waits for an event.
// A disabled, stopped or out-of-range event goes from the check to the result.
// Else the bucket head is read: an empty bucket takes a new arc; otherwise the
// chain is compared arc by arc, a hit at the head is counted, a hit below the
// head is counted and moved to the head, and a miss at its end takes a new arc.
// The walk does one arc-table read per cycle, so chain length sets the rate;
// the next request is taken only once the sequencer is back in its idle state.
// The finished result sits in the output register; the next event is accepted
// while it waits. When the receiver stalls, the sequencer holds the following
// result until the output register frees. Reset sets the control and the
// configuration registers, then sweeps every bucket-head entry to zero, one
// entry a cycle, with s_tready low; configuration writes are taken during the sweep.
module call_arc_counter_core
	import carc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // caller_pc[31:0], callee_pc[63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // status[2:0], arc_index[18:3], arc_count[50:19], zero
	input  logic        cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_wdata
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CHECK = 4'd2;
	localparam logic [3:0] S_HEAD  = 4'd3;
	localparam logic [3:0] S_CMP   = 4'd4;
	localparam logic [3:0] S_MOVE1 = 4'd5;
	localparam logic [3:0] S_MOVE2 = 4'd6;
	localparam logic [3:0] S_ALLOC = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;

	logic [3:0] state_q;

	// configuration
	logic                   enable_q;
	logic [PC_W-1:0]        text_base_q;
	logic [TEXT_SIZE_W-1:0] text_size_q;
	logic [ARC_LIMIT_W-1:0] arc_limit_q;

	logic [INDEX_W-1:0] last_q;
	logic               stopped_q;
	logic [BKT_W-1:0]   clr_q;

	logic [PC_W-1:0]  caller_q;
	logic [PC_W-1:0]  callee_q;
	logic [BKT_W-1:0] bkt_q;
	logic [ARC_W-1:0] head_q;
	logic [ARC_W-1:0] cur_q;
	logic [ARC_W-1:0] prev_q;
	logic [ARC_W-1:0] nxt_q;
	logic             first_q;

	logic [STATUS_W-1:0] res_st_q;
	logic [INDEX_W-1:0]  res_idx_q;
	logic [COUNT_W-1:0]  res_cnt_q;

	logic        m_tvalid_q;
	logic [55:0] m_tdata_q;

	// memory ports
	logic             hd_we, hd_re;
	logic [BKT_W-1:0] hd_waddr;
	logic [ARC_W-1:0] hd_wdata, hd_rdata;
	logic             ce_we, cn_we, nx_we, arc_re;
	logic [ARC_W-1:0] ce_waddr, cn_waddr, nx_waddr, arc_raddr, nx_wdata;
	logic [PC_W-1:0]  ce_rdata;
	logic [COUNT_W-1:0] cn_wdata, cn_rdata;
	logic [ARC_W-1:0] nx_rdata;

	// derived values
	logic [PC_W-1:0]    offset;
	logic [PC_W-1:0]    bkt_full;
	logic               out_rng;
	logic [INDEX_W:0]   eff_lim;
	logic [INDEX_W-1:0] alloc_idx;
	logic               alloc_bad;
	logic               hit;
	logic [COUNT_W-1:0] cnt_inc;
	logic               emit_go;

	always_comb begin
		offset    = caller_q - text_base_q;
		bkt_full  = offset / PC_W'(BUCKET_BYTES);
		out_rng   = (offset > PC_W'(text_size_q)) || (bkt_full >= PC_W'(BUCKETS));
		eff_lim   = ((INDEX_W+1)'(arc_limit_q) > (INDEX_W+1)'(ARC_CAP)) ?
		            (INDEX_W+1)'(ARC_CAP) : (INDEX_W+1)'(arc_limit_q);
		alloc_idx = last_q + INDEX_W'(1);
		alloc_bad = ((INDEX_W+1)'(alloc_idx) >= eff_lim) ||
		            ((INDEX_W+1)'(alloc_idx) >= (INDEX_W+1)'(ARCS));
		hit       = (ce_rdata == callee_q);
		cnt_inc   = cn_rdata + COUNT_W'(1);
		emit_go   = !m_tvalid_q || m_tready;
	end

	// memory port control
	always_comb begin
		hd_we    = 1'b0;
		hd_waddr = bkt_q;
		hd_wdata = cur_q;
		hd_re    = (state_q == S_CHECK);
		ce_we    = 1'b0;
		ce_waddr = alloc_idx[ARC_W-1:0];
		cn_we    = 1'b0;
		cn_waddr = cur_q;
		cn_wdata = cnt_inc;
		nx_we    = 1'b0;
		nx_waddr = alloc_idx[ARC_W-1:0];
		nx_wdata = head_q;
		arc_re   = 1'b0;
		arc_raddr = nx_rdata;
		unique case (state_q)
			S_CLEAR: begin
				hd_we    = 1'b1;
				hd_waddr = clr_q;
				hd_wdata = '0;
			end
			S_HEAD: begin
				arc_raddr = hd_rdata;
				arc_re    = (hd_rdata != '0);
			end
			S_CMP: begin
				if (hit) begin
					cn_we = 1'b1;
					hd_we = !first_q;
				end else begin
					arc_re = (nx_rdata != '0);
				end
			end
			S_MOVE1: begin
				nx_we    = 1'b1;
				nx_waddr = prev_q;
				nx_wdata = nxt_q;
			end
			S_MOVE2: begin
				nx_we    = 1'b1;
				nx_waddr = cur_q;
				nx_wdata = head_q;
			end
			S_ALLOC: begin
				if (!alloc_bad) begin
					ce_we    = 1'b1;
					cn_we    = 1'b1;
					cn_waddr = alloc_idx[ARC_W-1:0];
					cn_wdata = COUNT_W'(1);
					nx_we    = 1'b1;
					hd_we    = 1'b1;
					hd_wdata = alloc_idx[ARC_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	carc_ram #(.WIDTH(ARC_W), .DEPTH(BUCKETS)) u_heads (
		.clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
		.re(hd_re), .raddr(out_rng ? '0 : bkt_full[BKT_W-1:0]), .rdata(hd_rdata)
	);

	carc_ram #(.WIDTH(PC_W), .DEPTH(ARCS)) u_callee (
		.clk(clk), .we(ce_we), .waddr(ce_waddr), .wdata(callee_q),
		.re(arc_re), .raddr(arc_raddr), .rdata(ce_rdata)
	);

	carc_ram #(.WIDTH(COUNT_W), .DEPTH(ARCS)) u_count (
		.clk(clk), .we(cn_we), .waddr(cn_waddr), .wdata(cn_wdata),
		.re(arc_re), .raddr(arc_raddr), .rdata(cn_rdata)
	);

	carc_ram #(.WIDTH(ARC_W), .DEPTH(ARCS)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.re(arc_re), .raddr(arc_raddr), .rdata(nx_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			text_base_q <= '0;
			text_size_q <= TEXT_SIZE_W'(16384);
			arc_limit_q <= ARC_LIMIT_W'(4096);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_ENABLE:    enable_q    <= cfg_wdata[0];
				CFG_TEXT_BASE: text_base_q <= cfg_wdata;
				CFG_TEXT_SIZE: text_size_q <= cfg_wdata[TEXT_SIZE_W-1:0];
				CFG_ARC_LIMIT: arc_limit_q <= cfg_wdata[ARC_LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			last_q     <= '0;
			stopped_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && emit_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + BKT_W'(1);
					if (clr_q == BKT_W'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (!enable_q || stopped_q || out_rng) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					state_q <= (hd_rdata == '0) ? S_ALLOC : S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						state_q <= first_q ? S_EMIT : S_MOVE1;
					end else if (nx_rdata == '0) begin
						state_q <= S_ALLOC;
					end
				end
				S_MOVE1: state_q <= S_MOVE2;
				S_MOVE2: state_q <= S_EMIT;
				S_ALLOC: begin
					last_q <= alloc_idx;
					if (alloc_bad) begin
						stopped_q <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// event payload and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				caller_q <= s_tdata[31:0];
				callee_q <= s_tdata[63:32];
			end
			S_CHECK: begin
				bkt_q     <= bkt_full[BKT_W-1:0];
				res_idx_q <= '0;
				res_cnt_q <= '0;
				res_st_q  <= (!enable_q || stopped_q) ? STAT_OFF : STAT_RANGE;
			end
			S_HEAD: begin
				head_q  <= hd_rdata;
				cur_q   <= hd_rdata;
				first_q <= 1'b1;
			end
			S_CMP: begin
				if (hit) begin
					res_st_q  <= first_q ? STAT_HEAD_HIT : STAT_MOVED;
					res_idx_q <= INDEX_W'(cur_q);
					res_cnt_q <= cnt_inc;
					nxt_q     <= nx_rdata;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= nx_rdata;
					first_q <= 1'b0;
				end
			end
			S_ALLOC: begin
				if (alloc_bad) begin
					res_st_q  <= STAT_OVERFLOW;
					res_idx_q <= '0;
					res_cnt_q <= '0;
				end else begin
					res_st_q  <= STAT_NEW;
					res_idx_q <= alloc_idx;
					res_cnt_q <= COUNT_W'(1);
				end
			end
			S_EMIT: begin
				if (emit_go) begin
					m_tdata_q <= {5'b0, res_cnt_q, res_idx_q, res_st_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== sv/carc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module carc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/carc_checker.sv =====
// Port-level checks for the call arc counter, bound to call_arc_counter_core.
module carc_checker
	import carc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	logic [STATUS_W-1:0] st;
	assign st = m_tdata[2:0];

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one event at a time: ready drops after a request is taken
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high after accepting a request");

	a_no_arc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == STAT_RANGE || st == STAT_OFF || st == STAT_OVERFLOW)
		|-> m_tdata[50:3] == '0)
		else $error("failed event reports an arc");

	a_new_arc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == STAT_NEW |-> m_tdata[50:19] == 32'd1 && m_tdata[18:3] != '0)
		else $error("new arc with bad index or count");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> st == STAT_HEAD_HIT || st == STAT_MOVED || st == STAT_NEW ||
		st == STAT_RANGE || st == STAT_OFF || st == STAT_OVERFLOW)
		else $error("status code out of range");

endmodule

bind call_arc_counter_core carc_checker u_carc_checker (
	.clk(clk), .arst_n(arst_n),
	.s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
